FILE: hdl/grq_pkg.sv
// Shared types and constants for the grouped ready queue.
// No dependencies; every other file uses this package by scoped names.
`default_nettype none

package grq_pkg;

  localparam int NumProc  = 256;
  localparam int NumGroup = 256;

  localparam int FuncW   = 2;
  localparam int PidW    = $clog2(NumProc + 1);
  localparam int SlotW   = $clog2(NumProc);
  localparam int GidW    = $clog2(NumGroup);
  localparam int CntW    = $clog2(NumGroup + 1);
  localparam int StatusW = 3;

  // flag memories are cleared one entry per cycle after reset
  localparam int ClrDepth = (NumProc > NumGroup) ? NumProc : NumGroup;
  localparam int ClrW     = $clog2(ClrDepth);
  localparam logic [ClrW-1:0] ClrLast = ClrW'(ClrDepth - 1);

  localparam logic [FuncW-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FuncW-1:0] FUNC_ENQ  = 2'd1;

  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_LOADED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ENQ_GRP,
    S_ENQ_TOP,
    S_DEQ_FIFO,
    S_DEQ_TOP,
    S_DEQ_NEXT,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             grp_rd;
    logic             grp_we;
    logic [GidW-1:0]  grp_wdata;
    logic             nxt_rd;
    logic             nxt_we;
    logic [PidW-1:0]  nxt_wdata;
    logic             wait_rd;
    logic             wait_set;
    logic             wait_clr;
  } proc_cmd_t;

  typedef struct packed {
    logic [GidW-1:0] grp;
    logic [PidW-1:0] nxt;
    logic            waiting;
  } proc_rsp_t;

  typedef struct packed {
    logic [GidW-1:0] gid;
    logic            top_rd;
    logic            top_we;
    logic [PidW-1:0] top_wdata;
    logic            act_rd;
    logic            act_set;
    logic            act_clr;
    logic            push;
    logic            fifo_rd;
    logic            pop;
  } group_cmd_t;

  typedef struct packed {
    logic [PidW-1:0] top;
    logic [GidW-1:0] head;
    logic            active;
    logic            empty;
  } group_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/grq_req_if.sv
// Request channel of the grouped ready queue: valid/ready plus item fields.
// Depends on grq_pkg for field widths.
`default_nettype none

interface grq_req_if;
  logic                       valid;
  logic                       ready;
  logic [grq_pkg::FuncW-1:0]  func;
  logic [grq_pkg::PidW-1:0]   process_id;
  logic [grq_pkg::GidW-1:0]   group_id;

  modport source (output valid, func, process_id, group_id, input ready);
  modport sink   (input valid, func, process_id, group_id, output ready);
endinterface

`default_nettype wire

FILE: hdl/grq_rsp_if.sv
// Result channel of the grouped ready queue: valid/ready plus result fields.
// Depends on grq_pkg for field widths.
`default_nettype none

interface grq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [grq_pkg::StatusW-1:0]  status;
  logic [grq_pkg::PidW-1:0]     process_out;

  modport source (output valid, status, process_out, input ready);
  modport sink   (input valid, status, process_out, output ready);
endinterface

`default_nettype wire

FILE: hdl/grouped_ready_queue_top.sv
// Grouped ready queue top: sequencer, process and group tables, result register.
// Depends on grq_pkg, grq_req_if, grq_rsp_if, grq_proc_tbl, grq_group_tbl.
// After reset the block clears all 256 entries of its waiting and active
// flag memories, one entry per cycle, with ready low. Then one item is
// handled at a time; memory reads are registered and depend on each other.
// An enqueue reads group and waiting flag (and ends there if the process
// waits), then list top and active flag, then writes; a dequeue reads FIFO
// head, list top and link, then writes; a load or other item ends in its
// first step. The result sits in an output register: the next item is taken
// while the result waits, and last steps stall only while the register is full.
`default_nettype none

module grouped_ready_queue_top (
  input  wire logic  clk,
  input  wire logic  rst,
  grq_req_if.sink    req,
  grq_rsp_if.source  rsp
);

  grq_pkg::state_t   state, state_next;
  grq_pkg::proc_cmd_t  pcmd;
  grq_pkg::proc_rsp_t  prsp;
  grq_pkg::group_cmd_t gcmd;
  grq_pkg::group_rsp_t grsp;

  logic [grq_pkg::FuncW-1:0] func_r;
  logic [grq_pkg::PidW-1:0]  pid_r;
  logic [grq_pkg::GidW-1:0]  gin_r;
  logic [grq_pkg::GidW-1:0]  grp_r, grp_next;
  logic [grq_pkg::PidW-1:0]  proc_r, proc_next;
  logic [grq_pkg::ClrW-1:0]  clr_idx;

  logic                      out_valid;
  grq_pkg::status_t          out_status;
  logic [grq_pkg::PidW-1:0]  out_proc;

  logic                      out_free;
  logic                      finish;
  grq_pkg::status_t          fin_status;
  logic [grq_pkg::PidW-1:0]  fin_proc;
  logic                      pid_ok;
  logic [grq_pkg::PidW-1:0]  pid_m1;
  logic [grq_pkg::PidW-1:0]  top_m1;
  logic [grq_pkg::PidW-1:0]  proc_m1;

  grq_proc_tbl u_proc (
    .clk (clk),
    .rst (rst),
    .cmd (pcmd),
    .rsp (prsp)
  );

  grq_group_tbl u_group (
    .clk (clk),
    .rst (rst),
    .cmd (gcmd),
    .rsp (grsp)
  );

  assign req.ready = (state == grq_pkg::S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  assign pid_ok  = (pid_r != '0) && (int'(pid_r) <= grq_pkg::NumProc);
  assign pid_m1  = pid_r - 1'b1;
  assign top_m1  = grsp.top - 1'b1;
  assign proc_m1 = proc_r - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grq_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == grq_pkg::S_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      func_r <= req.func;
      pid_r  <= req.process_id;
      gin_r  <= req.group_id;
    end
    grp_r  <= grp_next;
    proc_r <= proc_next;
  end

  always_comb begin
    state_next = state;
    pcmd       = '0;
    gcmd       = '0;
    pcmd.slot  = pid_m1[grq_pkg::SlotW-1:0];
    gcmd.gid   = grp_r;
    finish     = 1'b0;
    fin_status = grq_pkg::ST_IGNORED;
    fin_proc   = '0;
    grp_next   = grp_r;
    proc_next  = proc_r;

    case (state)
      grq_pkg::S_CLEAR: begin
        pcmd.slot     = clr_idx[grq_pkg::SlotW-1:0];
        pcmd.wait_clr = 1'b1;
        gcmd.gid      = clr_idx[grq_pkg::GidW-1:0];
        gcmd.act_clr  = 1'b1;
        if (clr_idx == grq_pkg::ClrLast) begin
          state_next = grq_pkg::S_IDLE;
        end
      end

      grq_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = grq_pkg::S_EXEC;
        end
      end

      grq_pkg::S_EXEC: begin
        if (func_r == grq_pkg::FUNC_LOAD || func_r == grq_pkg::FUNC_ENQ) begin
          if (!pid_ok
              || (func_r == grq_pkg::FUNC_LOAD && int'(gin_r) >= grq_pkg::NumGroup)) begin
            fin_status = grq_pkg::ST_IGNORED;
            finish     = out_free;
          end else if (func_r == grq_pkg::FUNC_LOAD) begin
            fin_status     = grq_pkg::ST_LOADED;
            finish         = out_free;
            pcmd.grp_we    = out_free;
            pcmd.grp_wdata = gin_r;
          end else begin
            pcmd.grp_rd  = 1'b1;
            pcmd.wait_rd = 1'b1;
            state_next   = grq_pkg::S_ENQ_GRP;
          end
        end else if (grsp.empty) begin
          fin_status = grq_pkg::ST_EMPTY;
          finish     = out_free;
        end else begin
          gcmd.fifo_rd = 1'b1;
          state_next   = grq_pkg::S_DEQ_FIFO;
        end
      end

      grq_pkg::S_ENQ_GRP: begin
        gcmd.gid = prsp.grp;
        grp_next = prsp.grp;
        if (prsp.waiting) begin
          fin_status = grq_pkg::ST_IGNORED;
          finish     = out_free;
        end else begin
          gcmd.act_rd = 1'b1;
          gcmd.top_rd = 1'b1;
          state_next  = grq_pkg::S_ENQ_TOP;
        end
      end

      grq_pkg::S_ENQ_TOP: begin
        fin_status     = grq_pkg::ST_ENQUEUED;
        finish         = out_free;
        gcmd.top_we    = out_free;
        gcmd.top_wdata = pid_r;
        pcmd.nxt_we    = out_free;
        pcmd.nxt_wdata = grsp.top;
        pcmd.wait_set  = out_free;
        if (!grsp.active) begin
          // group joins the FIFO with this process as its only entry
          gcmd.act_set   = out_free;
          gcmd.push      = out_free;
          pcmd.nxt_wdata = '0;
        end
      end

      grq_pkg::S_DEQ_FIFO: begin
        gcmd.gid    = grsp.head;
        grp_next    = grsp.head;
        gcmd.top_rd = 1'b1;
        state_next  = grq_pkg::S_DEQ_TOP;
      end

      grq_pkg::S_DEQ_TOP: begin
        proc_next   = grsp.top;
        pcmd.slot   = top_m1[grq_pkg::SlotW-1:0];
        pcmd.nxt_rd = 1'b1;
        state_next  = grq_pkg::S_DEQ_NEXT;
      end

      grq_pkg::S_DEQ_NEXT: begin
        pcmd.slot      = proc_m1[grq_pkg::SlotW-1:0];
        fin_status     = grq_pkg::ST_DEQUEUED;
        fin_proc       = proc_r;
        finish         = out_free;
        gcmd.top_we    = out_free;
        gcmd.top_wdata = prsp.nxt;
        pcmd.wait_clr  = out_free;
        if (prsp.nxt == '0) begin
          gcmd.act_clr = out_free;
          gcmd.pop     = out_free;
        end
      end

      default: begin
        state_next = grq_pkg::S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = grq_pkg::S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status <= fin_status;
      out_proc   <= fin_proc;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.process_out = out_proc;

endmodule

`default_nettype wire

FILE: hdl/grq_proc_tbl.sv
// Per-process storage: group table, list links, waiting flags, all in registered-read
// memories; the top clears the waiting flags after reset. Depends on grq_pkg.
`default_nettype none

module grq_proc_tbl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire grq_pkg::proc_cmd_t cmd,
  output grq_pkg::proc_rsp_t      rsp
);

  logic [grq_pkg::GidW-1:0] grp_mem  [grq_pkg::NumProc];
  logic [grq_pkg::PidW-1:0] nxt_mem  [grq_pkg::NumProc];
  logic                     wait_mem [grq_pkg::NumProc];
  logic [grq_pkg::GidW-1:0] grp_q;
  logic [grq_pkg::PidW-1:0] nxt_q;
  logic                     wait_q;

  always_ff @(posedge clk) begin
    if (cmd.grp_we) begin
      grp_mem[cmd.slot] <= cmd.grp_wdata;
    end
    if (cmd.grp_rd) begin
      grp_q <= grp_mem[cmd.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nxt_we) begin
      nxt_mem[cmd.slot] <= cmd.nxt_wdata;
    end
    if (cmd.nxt_rd) begin
      nxt_q <= nxt_mem[cmd.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wait_set) begin
      wait_mem[cmd.slot] <= 1'b1;
    end else if (cmd.wait_clr) begin
      wait_mem[cmd.slot] <= 1'b0;
    end
    if (cmd.wait_rd) begin
      wait_q <= wait_mem[cmd.slot];
    end
  end

  assign rsp.grp     = grp_q;
  assign rsp.nxt     = nxt_q;
  assign rsp.waiting = wait_q;

  a_set_not_waiting: assert property (@(posedge clk) disable iff (rst)
    cmd.wait_set |-> !wait_mem[cmd.slot])
    else $error("process pushed while already waiting");

  a_set_clr_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wait_set && cmd.wait_clr))
    else $error("waiting flag set and cleared in the same cycle");

  a_one_read: assert property (@(posedge clk) disable iff (rst)
    !(cmd.grp_rd && cmd.nxt_rd))
    else $error("group and link read in the same cycle");

endmodule

`default_nettype wire

FILE: hdl/grq_group_tbl.sv
// Per-group storage: list tops, active flags and the group FIFO in
// registered-read memories, FIFO pointers in flops. Depends on grq_pkg.
`default_nettype none

module grq_group_tbl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire grq_pkg::group_cmd_t cmd,
  output grq_pkg::group_rsp_t      rsp
);

  logic [grq_pkg::PidW-1:0] top_mem  [grq_pkg::NumGroup];
  logic [grq_pkg::GidW-1:0] fifo_mem [grq_pkg::NumGroup];
  logic                     act_mem  [grq_pkg::NumGroup];
  logic [grq_pkg::PidW-1:0] top_q;
  logic [grq_pkg::GidW-1:0] head_q;
  logic                     act_q;
  logic [grq_pkg::GidW-1:0] rd_ptr;
  logic [grq_pkg::GidW-1:0] wr_ptr;
  logic [grq_pkg::CntW-1:0] count;

  localparam logic [grq_pkg::GidW-1:0] PtrLast = grq_pkg::GidW'(grq_pkg::NumGroup - 1);
  localparam logic [grq_pkg::CntW-1:0] CntFull = grq_pkg::CntW'(grq_pkg::NumGroup);

  always_ff @(posedge clk) begin
    if (cmd.top_we) begin
      top_mem[cmd.gid] <= cmd.top_wdata;
    end
    if (cmd.top_rd) begin
      top_q <= top_mem[cmd.gid];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act_set) begin
      act_mem[cmd.gid] <= 1'b1;
    end else if (cmd.act_clr) begin
      act_mem[cmd.gid] <= 1'b0;
    end
    if (cmd.act_rd) begin
      act_q <= act_mem[cmd.gid];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      fifo_mem[wr_ptr] <= cmd.gid;
    end
    if (cmd.fifo_rd) begin
      head_q <= fifo_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
        count  <= count + 1'b1;
      end else if (cmd.pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
        count  <= count - 1'b1;
      end
    end
  end

  assign rsp.top    = top_q;
  assign rsp.head   = head_q;
  assign rsp.active = act_q;
  assign rsp.empty  = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count != CntFull)
    else $error("group FIFO push when full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("group FIFO pop when empty");

  a_join_inactive: assert property (@(posedge clk) disable iff (rst)
    cmd.act_set |-> (!act_mem[cmd.gid] && cmd.push))
    else $error("group joined FIFO twice");

endmodule

`default_nettype wire
